### rtl/segment_tree_range_sum_core_defines.svh
// Assertion macros for the segment tree range sum core.
// Used by rtl files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SEGMENT_TREE_RANGE_SUM_CORE_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_CORE_DEFINES_SVH
`ifndef SYNTH
// checked property, disabled while in reset
`define SEGSUM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("segsum assertion failed");
// checked property, also active during reset
`define SEGSUM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("segsum assertion failed");
`else
`define SEGSUM_ASSERT(label, prop)
`define SEGSUM_ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/segsum_pkg.sv
// Shared types and constants for the segment tree range sum core.
// No dependencies; the core, sequencer and datapath refer to it by scoped names.
package segsum_pkg;

  localparam int ARRAY_SIZE = 1024;
  localparam int POS_W      = 10;
  localparam int LEAF_W     = $clog2(ARRAY_SIZE);
  localparam int NODE_W     = LEAF_W + 1;          // heap index, leaves at ARRAY_SIZE+i
  localparam int SPAN_W     = NODE_W + 1;          // exclusive bound may reach 2*ARRAY_SIZE
  localparam int NODE_DEPTH = 2 * ARRAY_SIZE;
  localparam int COUNT_W    = 11;
  localparam int DATA_W     = 64;
  localparam int APB_AW     = 2;
  localparam int APB_DW     = 32;

  localparam logic [APB_AW-1:0] REG_ELEMENT_COUNT = 2'd0;

  localparam logic KIND_SET   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DIFF,
    OP_UP,
    OP_QLEFT,
    OP_QRIGHT,
    OP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIFF,
    ST_UP,
    ST_QLEFT,
    ST_QRIGHT,
    ST_QDONE
  } st_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_query;    // word on the input is a query
    logic in_set_ok;   // word on the input is a set inside the array
    logic clr_last;    // clearing pass at the last node
    logic at_root;     // update walk reached node 1
    logic loop_done;   // query bounds met
    logic out_free;    // output register can take a word
  } dp_stat_t;

endpackage

### rtl/segment_tree_range_sum_core.sv
// Top level of the segment tree range sum core: APB register, sequencer, datapath.
// Depends on segsum_pkg, segsum_ctrl, segsum_dp (which holds segsum_ram).
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one word per item: in_kind 0 sets
//    element in_position to in_new_value, in_kind 1 asks for the sum over
//    in_position..in_range_right. Sets produce no result; queries produce one
//    word on out_valid/out_ready carrying out_range_total (wrapping 64-bit sum).
//  - The tree is a fixed heap of 2048 nodes in one RAM, leaves at 1024+i; the
//    element_count register only clips sets and query ranges, so rewriting it
//    needs no rebuild. Read at any time through prdata; pready is always high.
//  - Bound by the single read port of the node RAM, items are walked step by step: a
//    set does a leaf read, a leaf write, then one read-modify-write per level up to
//    the root; a set outside the array does nothing further. A query visits at most
//    11 tree levels, then loads its result into the output register, which drives
//    out_valid.
//  - in_ready is high only between items. The output register holds a result
//    while the receiver stalls; the next item is still taken, and a query that
//    finishes behind a stalled result waits until that word is taken.
//  - Reset (rst_n low, synchronous) sets element_count to 1024 and starts a
//    clearing pass over the 2048 RAM nodes, one per cycle; in_ready stays low
//    until that pass ends, register writes are taken throughout.
module segment_tree_range_sum_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [segsum_pkg::POS_W-1:0]         in_position,
  input  logic signed [segsum_pkg::DATA_W-1:0] in_new_value,
  input  logic [segsum_pkg::POS_W-1:0]         in_range_right,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [segsum_pkg::DATA_W-1:0] out_range_total,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [segsum_pkg::APB_AW-1:0]        paddr,
  input  logic [segsum_pkg::APB_DW-1:0]        pwdata,
  output logic [segsum_pkg::APB_DW-1:0]        prdata,
  output logic                                 pready
);

  localparam int CW = segsum_pkg::COUNT_W;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] count_eff;
  logic          cfg_wr;

  segsum_pkg::dp_cmd_t  cmd;
  segsum_pkg::dp_stat_t stat;

  // register write lands in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == segsum_pkg::REG_ELEMENT_COUNT);

  always_comb begin
    count_nxt = cfg_wr ? pwdata[CW-1:0] : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(segsum_pkg::ARRAY_SIZE);
    end else begin
      count_r <= count_nxt;
    end
  end

  // readback is the raw value; a count of zero acts as one, above the array as the array
  assign prdata = {{(segsum_pkg::APB_DW - CW){1'b0}}, count_r};

  always_comb begin
    if (count_r == '0) begin
      count_eff = CW'(1);
    end else if (count_r > CW'(segsum_pkg::ARRAY_SIZE)) begin
      count_eff = CW'(segsum_pkg::ARRAY_SIZE);
    end else begin
      count_eff = count_r;
    end
  end

  segsum_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  segsum_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .count_eff       (count_eff),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_new_value    (in_new_value),
    .in_range_right  (in_range_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_range_total (out_range_total)
  );

endmodule

### rtl/segsum_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module segsum_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/segsum_ctrl.sv
// Sequencer for the segment tree core: clear pass, set walk, query loop.
// Depends on segsum_pkg; drives the datapath through dp_cmd_t.
module segsum_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  segsum_pkg::dp_stat_t stat,
  output segsum_pkg::dp_cmd_t  cmd
);

  segsum_pkg::st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= segsum_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = segsum_pkg::OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      segsum_pkg::ST_CLEAR: begin
        cmd.op = segsum_pkg::OP_CLEAR;
        if (stat.clr_last) begin
          state_nxt = segsum_pkg::ST_IDLE;
        end
      end
      segsum_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = segsum_pkg::OP_LOAD;
          if (stat.in_query) begin
            state_nxt = segsum_pkg::ST_QLEFT;
          end else if (stat.in_set_ok) begin
            state_nxt = segsum_pkg::ST_DIFF;
          end
        end
      end
      segsum_pkg::ST_DIFF: begin
        cmd.op    = segsum_pkg::OP_DIFF;
        state_nxt = segsum_pkg::ST_UP;
      end
      segsum_pkg::ST_UP: begin
        cmd.op = segsum_pkg::OP_UP;
        if (stat.at_root) begin
          state_nxt = segsum_pkg::ST_IDLE;
        end
      end
      segsum_pkg::ST_QLEFT: begin
        if (stat.loop_done) begin
          state_nxt = segsum_pkg::ST_QDONE;
        end else begin
          cmd.op    = segsum_pkg::OP_QLEFT;
          state_nxt = segsum_pkg::ST_QRIGHT;
        end
      end
      segsum_pkg::ST_QRIGHT: begin
        cmd.op    = segsum_pkg::OP_QRIGHT;
        state_nxt = segsum_pkg::ST_QLEFT;
      end
      segsum_pkg::ST_QDONE: begin
        if (stat.out_free) begin
          cmd.op    = segsum_pkg::OP_OUT;
          state_nxt = segsum_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = segsum_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/segsum_dp.sv
// Datapath of the segment tree core: node memory, bounds, accumulator, output register.
// Depends on segsum_pkg, segsum_ram and the assertion macro header.
`include "segment_tree_range_sum_core_defines.svh"

module segsum_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  segsum_pkg::dp_cmd_t                 cmd,
  output segsum_pkg::dp_stat_t                stat,
  input  logic [segsum_pkg::COUNT_W-1:0]      count_eff,
  input  logic                                in_kind,
  input  logic [segsum_pkg::POS_W-1:0]        in_position,
  input  logic signed [segsum_pkg::DATA_W-1:0] in_new_value,
  input  logic [segsum_pkg::POS_W-1:0]        in_range_right,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [segsum_pkg::DATA_W-1:0] out_range_total
);

  localparam int NW = segsum_pkg::NODE_W;
  localparam int SW = segsum_pkg::SPAN_W;
  localparam int CW = segsum_pkg::COUNT_W;
  localparam int DW = segsum_pkg::DATA_W;

  logic [NW-1:0] node_r, node_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] lo_r, lo_nxt;
  logic [SW-1:0] hi_r, hi_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [DW-1:0] diff_r, diff_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  logic          acc_pend_r, acc_pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          ram_we, ram_re;
  logic [NW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] pos_ext, right_ext, right_eff;
  logic          q_empty;
  logic [NW-1:0] leaf_addr;
  logic [SW-1:0] lo_load, hi_load, hi_dec;

  segsum_ram #(
    .WIDTH (DW),
    .DEPTH (segsum_pkg::NODE_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // query bounds in heap form: [lo, hi) over leaves, right end clamped to the array
  always_comb begin
    pos_ext   = CW'(in_position);
    right_ext = CW'(in_range_right);
    q_empty   = (in_position > in_range_right) || (pos_ext >= count_eff);
    right_eff = (right_ext >= count_eff) ? (count_eff - CW'(1)) : right_ext;
    leaf_addr = {1'b1, in_position};
    lo_load   = q_empty ? '0 : SW'(leaf_addr);
    hi_load   = q_empty ? '0 :
                (SW'(segsum_pkg::ARRAY_SIZE) + SW'(right_eff) + SW'(1));
    hi_dec    = hi_r - SW'(1);
  end

  always_comb begin
    node_nxt      = node_r;
    clr_nxt       = clr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    val_nxt       = val_r;
    diff_nxt      = diff_r;
    acc_nxt       = acc_pend_r ? (acc_r + ram_rdata) : acc_r;
    acc_pend_nxt  = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = node_r;
    ram_wdata     = val_r;
    ram_re        = 1'b0;
    ram_raddr     = node_r >> 1;
    case (cmd.op)
      segsum_pkg::OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + NW'(1);
      end
      segsum_pkg::OP_LOAD: begin
        val_nxt   = in_new_value;
        node_nxt  = leaf_addr;
        lo_nxt    = lo_load;
        hi_nxt    = hi_load;
        acc_nxt   = '0;
        ram_re    = stat.in_set_ok;
        ram_raddr = leaf_addr;
      end
      segsum_pkg::OP_DIFF: begin
        // old leaf is on the read port; leaf takes the new value
        diff_nxt = val_r - ram_rdata;
        ram_we   = 1'b1;
        ram_re   = 1'b1;
        node_nxt = node_r >> 1;
      end
      segsum_pkg::OP_UP: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata + diff_r;
        ram_re    = !stat.at_root;
        node_nxt  = node_r >> 1;
      end
      segsum_pkg::OP_QLEFT: begin
        if (lo_r[0]) begin
          ram_re       = 1'b1;
          ram_raddr    = lo_r[NW-1:0];
          lo_nxt       = lo_r + SW'(1);
          acc_pend_nxt = 1'b1;
        end
      end
      segsum_pkg::OP_QRIGHT: begin
        if (hi_r[0]) begin
          ram_re       = 1'b1;
          ram_raddr    = hi_dec[NW-1:0];
          acc_pend_nxt = 1'b1;
        end
        lo_nxt = lo_r >> 1;
        hi_nxt = hi_r >> 1;
      end
      segsum_pkg::OP_OUT: begin
        out_data_nxt  = acc_r;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      acc_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      acc_pend_r  <= acc_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    val_r      <= val_nxt;
    diff_r     <= diff_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    stat.in_query  = (in_kind == segsum_pkg::KIND_QUERY);
    stat.in_set_ok = (in_kind == segsum_pkg::KIND_SET) && (pos_ext < count_eff);
    stat.clr_last  = (clr_r == NW'(segsum_pkg::NODE_DEPTH - 1));
    stat.at_root   = (node_r == NW'(1));
    stat.loop_done = (lo_r >= hi_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_range_total = out_data_r;

  // result load never overwrites a word still waiting
  `SEGSUM_ASSERT(a_out_no_overrun, (cmd.op == segsum_pkg::OP_OUT) |-> stat.out_free)
  // accumulate only the word fetched by a query step
  `SEGSUM_ASSERT(a_acc_from_query, acc_pend_r |-> ($past(cmd.op) == segsum_pkg::OP_QLEFT || $past(cmd.op) == segsum_pkg::OP_QRIGHT))
  // update walk stays inside the tree
  `SEGSUM_ASSERT(a_up_in_tree, (cmd.op == segsum_pkg::OP_UP) |-> (node_r != '0))
  // a left fetch is issued only while the bounds are open
  `SEGSUM_ASSERT(a_qleft_open, (cmd.op == segsum_pkg::OP_QLEFT) |-> (lo_r < hi_r))
  // nothing leaves the block straight out of reset
  `SEGSUM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid_r)

endmodule

### tb/segment_tree_range_sum_core_tb.sv
// Self-checking testbench for segment_tree_range_sum_core: point sets and range-sum queries.
// Needs only segsum_pkg and the rtl of the core; keeps a flat element array as its
// predictor.
module segment_tree_range_sum_core_tb;
  import segsum_pkg::*;

  // sets make no result, so allow this much after the last sum for a trailing set to finish
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic                     kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] new_value;
    logic [POS_W-1:0]         range_right;
  } seg_word_t;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic                     in_kind        = KIND_SET;
  logic [POS_W-1:0]         in_position    = '0;
  logic signed [DATA_W-1:0] in_new_value   = '0;
  logic [POS_W-1:0]         in_range_right = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic signed [DATA_W-1:0] out_range_total;
  logic                     psel           = 1'b0;
  logic                     penable        = 1'b0;
  logic                     pwrite         = 1'b0;
  logic [APB_AW-1:0]        paddr          = REG_ELEMENT_COUNT;
  logic [APB_DW-1:0]        pwdata         = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  segment_tree_range_sum_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_new_value    (in_new_value),
    .in_range_right  (in_range_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_range_total (out_range_total),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: the plain element array plus the effective element count.
  // Any range sum of the tree equals the wrapping sum of these elements, so no
  // node sums are kept. Leaves past the count keep their values across count
  // rewrites and come back into play when the count grows again.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] leaf_model [ARRAY_SIZE];
  int unsigned              live_count = ARRAY_SIZE;

  seg_word_t                words_pending [$];  // filled by the stimulus, drained by the driver
  logic signed [DATA_W-1:0] sums_due [$];       // expected range totals, oldest first
  int                       words_open   = 0;   // queued or on the bus, not yet accepted
  bit                       calm         = 1'b0; // last phase: no idling on either side
  int                       send_gap     = 0;
  int                       stall_left   = 0;
  int                       mismatches   = 0;
  int                       sets_seen    = 0;
  int                       queries_seen = 0;
  int                       sums_checked = 0;
  int                       count_writes = 0;

  function automatic int unsigned clip_count(logic [COUNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > ARRAY_SIZE) return ARRAY_SIZE;
    return 32'(raw);
  endfunction

  // wrapping sum over the clipped range; empty range or left end past the array gives 0
  function automatic logic signed [DATA_W-1:0] range_total_of(int unsigned lo, int unsigned hi);
    logic signed [DATA_W-1:0] acc;
    acc = '0;
    if (lo > hi || lo >= live_count) return acc;
    if (hi > live_count - 1) hi = live_count - 1;
    for (int unsigned i = lo; i <= hi; i++) acc += leaf_model[i];
    return acc;
  endfunction

  // Update the predictor with one accepted word.
  function automatic void apply_word(seg_word_t w);
    if (w.kind == KIND_SET) begin
      sets_seen++;
      // a set outside the array is dropped
      if (w.position < live_count) leaf_model[w.position] = w.new_value;
    end else begin
      queries_seen++;
      sums_due.push_back(range_total_of(32'(w.position), 32'(w.range_right)));
    end
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] want,
                                 logic [DATA_W-1:0] got);
    $display("MISMATCH: %s: expected %h got %h", what, want, got);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. Valid is held with a stable payload until accepted. Each
  // word's effect is folded into the predictor at the edge where it is taken,
  // so sets and queries are predicted in acceptance order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    seg_word_t w;
    logic      show;
    show = in_valid;
    if (!rst_n) begin
      show = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        w.kind        = in_kind;
        w.position    = in_position;
        w.new_value   = in_new_value;
        w.range_right = in_range_right;
        apply_word(w);
        words_open--;
        show = 1'b0;
      end
      if (!show) begin
        // random idle bursts; send_gap counts down what is left of one
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 18);
        end else if (words_pending.size() != 0) begin
          w = words_pending.pop_front();
          in_kind        <= w.kind;
          in_position    <= w.position;
          in_new_value   <= w.new_value;
          in_range_right <= w.range_right;
          show = 1'b1;
        end
      end
    end
    in_valid <= show;
  end

  // ---------------------------------------------------------------------------
  // Result monitor with random receiver stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sum_monitor
    logic                     take;
    logic signed [DATA_W-1:0] want;
    take = 1'b1;
    if (!rst_n) begin
      take = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sums_due.size() == 0) begin
          report_mismatch("range_total with no query waiting", '0, out_range_total);
        end else begin
          want = sums_due.pop_front();
          if (out_range_total !== want) report_mismatch("range_total", want, out_range_total);
          sums_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 18);
        take = 1'b0;
      end
    end
    out_ready <= take;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic kind, int unsigned pos, logic signed [DATA_W-1:0] val,
                            int unsigned right);
    seg_word_t w;
    w.kind        = kind;
    w.position    = pos[POS_W-1:0];
    w.new_value   = val;
    w.range_right = right[POS_W-1:0];
    words_pending.push_back(w);
    words_open++;
  endtask

  // Mostly well-formed words inside the current array, with a share of sets
  // outside it, empty and reversed ranges, ranges past the end, and noise.
  function automatic seg_word_t random_word();
    seg_word_t   w;
    int unsigned top;
    int unsigned pick;
    top           = live_count - 1;
    w.new_value   = {$urandom, $urandom};
    w.position    = POS_W'($urandom);
    w.range_right = POS_W'($urandom);
    w.kind        = ($urandom_range(0, 1) == 0) ? KIND_SET : KIND_QUERY;
    pick          = $urandom_range(0, 99);
    if (w.kind == KIND_SET) begin
      if (pick < 85) w.position = POS_W'($urandom_range(0, top));
      case ($urandom_range(0, 9))
        0: w.new_value = {1'b0, {(DATA_W-1){1'b1}}};
        1: w.new_value = {1'b1, {(DATA_W-1){1'b0}}};
        2, 3: begin
          w.new_value = DATA_W'($urandom_range(0, 200));
          w.new_value = w.new_value - DATA_W'(100);
        end
        default: ;
      endcase
    end else if (pick < 75) begin
      w.position    = POS_W'($urandom_range(0, top));
      w.range_right = POS_W'($urandom_range(w.position, top));
    end else if (pick < 85) begin
      // reversed range: left end above right end
      w.position    = POS_W'($urandom_range(1, ARRAY_SIZE - 1));
      w.range_right = POS_W'($urandom_range(0, w.position - 1));
    end else if (pick < 92) begin
      // running past the end of the array
      w.position    = POS_W'($urandom_range(0, top));
      w.range_right = POS_W'($urandom_range(top, ARRAY_SIZE - 1));
    end
    return w;
  endfunction

  // APB write: setup cycle, then the access cycle; taken at the edge closing it.
  task automatic write_count(logic [COUNT_W-1:0] raw);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ELEMENT_COUNT;
    pwdata  <= APB_DW'(raw);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    live_count = clip_count(raw);
    count_writes++;
  endtask

  // Hold the sender until every queued word is taken and every sum is back,
  // then let a trailing set finish its walk to the root.
  task automatic wait_idle();
    while (words_open != 0 || sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int          phase_counts [6] = '{2047, 1, 7, 300, 1024, 513};
  int          phase_words  [6] = '{250, 100, 250, 300, 300, 250};

  initial begin : sequence_main
    for (int i = 0; i < ARRAY_SIZE; i++) leaf_model[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset value, written explicitly; writes are taken during the clearing pass
    write_count(COUNT_W'(ARRAY_SIZE));

    // extremes of the value range, both ends of the array, full-range wrap
    queue_word(KIND_SET, 0, {1'b0, {(DATA_W-1){1'b1}}}, 0);
    queue_word(KIND_SET, ARRAY_SIZE - 1, {1'b1, {(DATA_W-1){1'b0}}}, ARRAY_SIZE - 1);
    queue_word(KIND_SET, 512, -1, 0);
    queue_word(KIND_SET, 511, 5, 0);
    queue_word(KIND_QUERY, 0, 0, ARRAY_SIZE - 1);
    queue_word(KIND_QUERY, 0, -1, 0);
    queue_word(KIND_QUERY, ARRAY_SIZE - 1, 0, ARRAY_SIZE - 1);
    queue_word(KIND_QUERY, 511, 0, 512);
    queue_word(KIND_SET, 0, 1, ARRAY_SIZE - 1);   // overwrite: path gets a difference
    queue_word(KIND_QUERY, 0, 0, ARRAY_SIZE - 1);
    queue_word(KIND_QUERY, 7, 0, 3);              // reversed range
    queue_word(KIND_QUERY, 1, 0, 510);            // untouched span sums to zero
    wait_idle();

    // count of zero acts as a single element
    write_count('0);
    queue_word(KIND_QUERY, 0, 0, ARRAY_SIZE - 1); // clipped to element 0
    queue_word(KIND_SET, 1, 99, 0);               // outside the array, dropped
    queue_word(KIND_QUERY, 1, 0, 1);              // left end past the array
    queue_word(KIND_SET, 0, -7, 0);
    queue_word(KIND_QUERY, 0, 0, 0);
    queue_word(KIND_QUERY, 0, 0, 5);
    wait_idle();

    // random phases over several counts; the sender drains fully between them
    for (int p = 0; p < 6; p++) begin
      if (p == 5) calm = 1'b1;
      write_count(COUNT_W'(phase_counts[p]));
      repeat (phase_words[p]) begin
        words_pending.push_back(random_word());
        words_open++;
      end
      wait_idle();
    end

    $display("covered %0d sets and %0d queries over %0d element count settings",
             sets_seen, queries_seen, count_writes);
    $display("%0d range totals compared, %0d mismatches", sums_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("timeout: %0d words unsent, %0d sums outstanding", words_open, sums_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
